>>> hw/rtl/fsat_pkg.sv
package fsat_pkg;

    // Field widths fixed by the interface.
    localparam int FLOW_W = 16;
    localparam int SUM_W  = 36;
    localparam int CFG_W  = 11;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]       DIM_RESET        = 11'd1024;

    // Digit-by-digit square root of a 32-bit sum of squares.
    localparam int SQRT_IN_W   = 32;
    localparam int SQRT_OUT_W  = 16;
    localparam int SQRT_REM_W  = 19;
    localparam int SQRT_STEPS  = SQRT_IN_W / 2;
    localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take the input word, start the line buffer read
        logic mul_x;       // square the horizontal component
        logic mul_y;       // add the square of the vertical component
        logic sqrt_start;  // launch the square root
        logic accumulate;  // update sums, write line buffer, load the output
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sqrt_last;    // the square root takes its final step this cycle
        logic out_blocked;  // the output register holds a word not yet taken
    } status_t;

endpackage

>>> hw/rtl/fsat_ram.sv
module fsat_ram #(
    parameter int WIDTH = 108,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/fsat_isqrt.sv
module fsat_isqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [fsat_pkg::SQRT_IN_W-1:0]   radicand,
    output logic                             last_step,
    output logic [fsat_pkg::SQRT_OUT_W-1:0]  root
);

    // Two radicand bits enter the remainder in each step.
    logic                               busy_reg, busy_next;
    logic [fsat_pkg::SQRT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [fsat_pkg::SQRT_IN_W-1:0]     val_reg, val_next;
    logic [fsat_pkg::SQRT_REM_W-1:0]    rem_reg, rem_next;
    logic [fsat_pkg::SQRT_OUT_W-1:0]    root_reg, root_next;
    logic [fsat_pkg::SQRT_REM_W-1:0]    rem_shift;
    logic [fsat_pkg::SQRT_REM_W-1:0]    trial;

    assign rem_shift = {rem_reg[fsat_pkg::SQRT_REM_W-3:0],
                        val_reg[fsat_pkg::SQRT_IN_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign last_step = busy_reg && (cnt_reg == fsat_pkg::SQRT_CNT_W'(fsat_pkg::SQRT_STEPS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[fsat_pkg::SQRT_IN_W-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[fsat_pkg::SQRT_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[fsat_pkg::SQRT_OUT_W-2:0], 1'b0};
            end
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule

>>> hw/rtl/fsat_ctrl.sv
module fsat_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fsat_pkg::status_t   status,
    output fsat_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MULX  = 3'd1;
    localparam logic [2:0] S_MULY  = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                if (status.sqrt_last)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (!status.out_blocked)
                begin
                    cmd.accumulate = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

>>> hw/rtl/fsat_datapath.sv
module fsat_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_enable,
    input  logic [fsat_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fsat_pkg::CFG_W-1:0]          cfg_data,
    input  logic signed [fsat_pkg::FLOW_W-1:0]  flow_x,
    input  logic signed [fsat_pkg::FLOW_W-1:0]  flow_y,
    input  fsat_pkg::cmd_t                      cmd,
    output fsat_pkg::status_t                   status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fsat_pkg::SUM_W-1:0]          sum_x,
    output logic [fsat_pkg::SUM_W-1:0]          sum_y,
    output logic [fsat_pkg::SUM_W-1:0]          sum_magnitude,
    output logic                                frame_done
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int RUN_W   = fsat_pkg::FLOW_W + COL_W;
    localparam int DIM_A   = (COL_W + 1 > ROW_W + 1) ? COL_W + 1 : ROW_W + 1;
    localparam int DIM_W   = (DIM_A > fsat_pkg::CFG_W) ? DIM_A : fsat_pkg::CFG_W;
    localparam int SUM_W   = fsat_pkg::SUM_W;
    localparam int ENTRY_W = 3 * SUM_W;

    logic [fsat_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [COL_W-1:0]           col_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [RUN_W-1:0]           run_x_reg, run_y_reg, run_mag_reg;
    logic                       out_valid_reg;
    logic                       frame_done_reg;
    logic [SUM_W-1:0]           sum_x_reg, sum_y_reg, sum_mag_reg;

    logic signed [fsat_pkg::FLOW_W-1:0] fx_reg, fy_reg;
    logic [fsat_pkg::SQRT_IN_W-1:0]     sqx_reg, sq_reg;
    logic signed [fsat_pkg::SQRT_IN_W-1:0] sqx_prod, sqy_prod;

    logic [DIM_W-1:0] w_eff, h_eff, col_ext, row_ext, col_inc, row_inc;
    logic             wrap_now, col_wrap, row_wrap, row_nz;
    logic [COL_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] below_data;
    logic [SUM_W-1:0] below_x, below_y, below_mag;
    logic [RUN_W-1:0] run_x_next, run_y_next, run_mag_next;
    logic [SUM_W-1:0] acc_x, acc_y, acc_mag;
    logic [fsat_pkg::SQRT_OUT_W-1:0] magnitude;
    logic             sqrt_last;

    // Register values out of range are clamped to one and to the maximum.
    always_comb
    begin
        priority if (frame_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (DIM_W'(frame_width_reg) > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(frame_width_reg);
        priority if (frame_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (DIM_W'(frame_height_reg) > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = DIM_W'(frame_height_reg);
    end

    assign col_ext  = DIM_W'(col_reg);
    assign row_ext  = DIM_W'(row_reg);
    assign col_inc  = col_ext + DIM_W'(1);
    assign row_inc  = row_ext + DIM_W'(1);
    assign wrap_now = (col_ext >= w_eff) || (row_ext >= h_eff);
    assign col_wrap = (col_inc >= w_eff);
    assign row_wrap = (row_inc >= h_eff);
    assign row_nz   = (row_reg != '0);
    assign rd_addr  = wrap_now ? '0 : col_reg;

    assign sqx_prod = fx_reg * fx_reg;
    assign sqy_prod = fy_reg * fy_reg;

    fsat_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.sqrt_start),
        .radicand  (sq_reg),
        .last_step (sqrt_last),
        .root      (magnitude)
    );

    // One entry per column holds the three sums of the row below.
    fsat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk     (clk),
        .wr_en   (cmd.accumulate),
        .wr_addr (col_reg),
        .wr_data ({acc_x, acc_y, acc_mag}),
        .rd_en   (cmd.load),
        .rd_addr (rd_addr),
        .rd_data (below_data)
    );

    assign below_x   = below_data[3*SUM_W-1 -: SUM_W];
    assign below_y   = below_data[2*SUM_W-1 -: SUM_W];
    assign below_mag = below_data[SUM_W-1:0];

    assign run_x_next   = run_x_reg + {{(RUN_W-fsat_pkg::FLOW_W){fx_reg[fsat_pkg::FLOW_W-1]}},
                                       fx_reg};
    assign run_y_next   = run_y_reg + {{(RUN_W-fsat_pkg::FLOW_W){fy_reg[fsat_pkg::FLOW_W-1]}},
                                       fy_reg};
    assign run_mag_next = run_mag_reg + RUN_W'(magnitude);

    assign acc_x   = {{(SUM_W-RUN_W){run_x_next[RUN_W-1]}}, run_x_next}
                   + (row_nz ? below_x : '0);
    assign acc_y   = {{(SUM_W-RUN_W){run_y_next[RUN_W-1]}}, run_y_next}
                   + (row_nz ? below_y : '0);
    assign acc_mag = SUM_W'(run_mag_next) + (row_nz ? below_mag : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= fsat_pkg::DIM_RESET;
            frame_height_reg <= fsat_pkg::DIM_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            run_x_reg        <= '0;
            run_y_reg        <= '0;
            run_mag_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write_enable &&
                (cfg_index == fsat_pkg::REG_FRAME_WIDTH ||
                 cfg_index == fsat_pkg::REG_FRAME_HEIGHT))
            begin
                if (cfg_index == fsat_pkg::REG_FRAME_WIDTH)
                    frame_width_reg <= cfg_data;
                else
                    frame_height_reg <= cfg_data;
                col_reg     <= '0;
                row_reg     <= '0;
                run_x_reg   <= '0;
                run_y_reg   <= '0;
                run_mag_reg <= '0;
            end
            else if (cmd.load && wrap_now)
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                run_x_reg   <= '0;
                run_y_reg   <= '0;
                run_mag_reg <= '0;
            end
            else if (cmd.accumulate)
            begin
                out_valid_reg <= 1'b1;
                if (col_wrap)
                begin
                    col_reg     <= '0;
                    run_x_reg   <= '0;
                    run_y_reg   <= '0;
                    run_mag_reg <= '0;
                    row_reg     <= row_wrap ? '0 : row_inc[ROW_W-1:0];
                end
                else
                begin
                    col_reg     <= col_inc[COL_W-1:0];
                    run_x_reg   <= run_x_next;
                    run_y_reg   <= run_y_next;
                    run_mag_reg <= run_mag_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fx_reg <= flow_x;
            fy_reg <= flow_y;
        end
        if (cmd.mul_x)
        begin
            sqx_reg <= sqx_prod;
        end
        if (cmd.mul_y)
        begin
            sq_reg <= sqx_reg + sqy_prod;
        end
        if (cmd.accumulate)
        begin
            sum_x_reg      <= acc_x;
            sum_y_reg      <= acc_y;
            sum_mag_reg    <= acc_mag;
            frame_done_reg <= col_wrap && row_wrap;
        end
    end

    assign status.sqrt_last   = sqrt_last;
    assign status.out_blocked = out_valid_reg && out_stall;

    assign out_valid     = out_valid_reg;
    assign sum_x         = sum_x_reg;
    assign sum_y         = sum_y_reg;
    assign sum_magnitude = sum_mag_reg;
    assign frame_done    = frame_done_reg;

endmodule

>>> hw/rtl/flow_summed_area_table.sv
// Summed-area table of a two-channel flow field, anchored at the bottom-right
// corner. Flow words (signed Q7.8 x and y) enter in reverse raster order, the
// bottom-right pixel first, and each produces one result word with the sums of
// x, y and floor(sqrt(x*x + y*y)) over the rectangle from that pixel to the
// bottom-right corner; frame_done marks the top-left pixel. The block works on
// one word at a time and takes no new word until it is through with the last:
// it takes the word, does the two squaring multiplies, launches the square
// root, runs it (two radicand bits per step), and then, once the output
// register can take a result, combines the sums and writes the line buffer.
// A finished result waits in the output register while the next word is
// already being taken and computed. Writing frame_width or frame_height
// restarts the frame; write them only while the block is idle. The line buffer
// needs no clearing after reset, since the bottom row ignores what it reads.
module flow_summed_area_table #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration: index 0 is frame_width, index 1 is frame_height.
    input  logic                                cfg_write_enable,
    input  logic [fsat_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fsat_pkg::CFG_W-1:0]          cfg_data,

    // Input flow words.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fsat_pkg::FLOW_W-1:0]  flow_x,
    input  logic signed [fsat_pkg::FLOW_W-1:0]  flow_y,

    // Result words.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fsat_pkg::SUM_W-1:0]   sum_x,
    output logic signed [fsat_pkg::SUM_W-1:0]   sum_y,
    output logic [fsat_pkg::SUM_W-1:0]          sum_magnitude,
    output logic                                frame_done
);

    fsat_pkg::cmd_t    cmd;
    fsat_pkg::status_t status;
    logic [fsat_pkg::SUM_W-1:0] sum_x_bits;
    logic [fsat_pkg::SUM_W-1:0] sum_y_bits;

    // The controller sequences each word through the squaring, the square
    // root and the final accumulation.
    fsat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the positions, the running row
    // sums, the line buffer of the row below and the output register.
    fsat_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .flow_x           (flow_x),
        .flow_y           (flow_y),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sum_x            (sum_x_bits),
        .sum_y            (sum_y_bits),
        .sum_magnitude    (sum_magnitude),
        .frame_done       (frame_done)
    );

    // The sums are two's complement; only the view changes here.
    assign sum_x = $signed(sum_x_bits);
    assign sum_y = $signed(sum_y_bits);

endmodule

>>> hw/rtl/fsat_checker.sv
module fsat_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [fsat_pkg::SUM_W-1:0]   sum_x,
    input logic signed [fsat_pkg::SUM_W-1:0]   sum_y,
    input logic [fsat_pkg::SUM_W-1:0]          sum_magnitude,
    input logic                                frame_done
);

    // Each word keeps the block busy, with its input stalled, after it is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall ##1 in_stall)
        else $error("input taken again too soon after a word");

    // A result appears only at the end of a word's processing.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the block was idle");

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sum_x) && $stable(sum_y)
                                      && $stable(sum_magnitude) && $stable(frame_done)))
        else $error("stalled result changed");

endmodule

bind flow_summed_area_table fsat_checker u_fsat_checker (.*);

>>> test/flow_sums_checker.sv
module flow_sums_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_enable,
    input  logic [fsat_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fsat_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [fsat_pkg::FLOW_W-1:0]  flow_x,
    input  logic signed [fsat_pkg::FLOW_W-1:0]  flow_y,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [fsat_pkg::SUM_W-1:0]   sum_x,
    input  logic signed [fsat_pkg::SUM_W-1:0]   sum_y,
    input  logic [fsat_pkg::SUM_W-1:0]          sum_magnitude,
    input  logic                                frame_done,
    output int                                  failures,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [fsat_pkg::SUM_W-1:0] x;
        logic signed [fsat_pkg::SUM_W-1:0] y;
        logic [fsat_pkg::SUM_W-1:0]        magnitude;
        logic                              done;
    } area_sums_t;

    area_sums_t sums_due[$];

    // Rectangle sums of the row below, by column, and the sums of the
    // current row to the right of the pixel.
    longint below_x [MAX_WIDTH];
    longint below_y [MAX_WIDTH];
    longint below_mag [MAX_WIDTH];
    longint run_x;
    longint run_y;
    longint run_mag;
    int col_pos;
    int row_pos;
    logic [fsat_pkg::CFG_W-1:0] width_reg;
    logic [fsat_pkg::CFG_W-1:0] height_reg;

    function automatic longint floor_sqrt(input longint sq);
        longint root;
        longint trial;
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root;
    endfunction

    function automatic int clamp_dim(input logic [fsat_pkg::CFG_W-1:0] v, input int limit);
        if (v == 0)
            return 1;
        return (v > limit) ? limit : int'(v);
    endfunction

    function automatic void restart_frame();
        run_x = 0;
        run_y = 0;
        run_mag = 0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic area_sums_t predict_area_sums(
        input logic signed [fsat_pkg::FLOW_W-1:0] fx,
        input logic signed [fsat_pkg::FLOW_W-1:0] fy
    );
        int w;
        int h;
        int col;
        longint x;
        longint y;
        longint sx;
        longint sy;
        longint sm;
        area_sums_t r;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        x = fx;
        y = fy;
        if (col_pos >= w || row_pos >= h)
            restart_frame();
        col = col_pos;
        run_x += x;
        run_y += y;
        run_mag += floor_sqrt(x * x + y * y);
        sx = run_x;
        sy = run_y;
        sm = run_mag;
        // The bottom row has nothing below it.
        if (row_pos != 0)
        begin
            sx += below_x[col];
            sy += below_y[col];
            sm += below_mag[col];
        end
        below_x[col] = sx;
        below_y[col] = sy;
        below_mag[col] = sm;
        r.done = 1'b0;
        col_pos = col + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            run_x = 0;
            run_y = 0;
            run_mag = 0;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
                r.done = 1'b1;
            end
        end
        r.x = sx[fsat_pkg::SUM_W-1:0];
        r.y = sy[fsat_pkg::SUM_W-1:0];
        r.magnitude = sm[fsat_pkg::SUM_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        area_sums_t want;
        if (!rst_n)
        begin
            width_reg = fsat_pkg::DIM_RESET;
            height_reg = fsat_pkg::DIM_RESET;
            restart_frame();
            sums_due.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            // A result leaving at this edge belongs to an older word, so it is
            // checked before a word entering at the same edge is predicted.
            if (out_valid && !out_stall)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("result word with no sums expected");
                    failures++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (sum_x !== want.x)
                    begin
                        $error("sum_x: expected %0d, actual %0d", $signed(want.x), sum_x);
                        failures++;
                    end
                    if (sum_y !== want.y)
                    begin
                        $error("sum_y: expected %0d, actual %0d", $signed(want.y), sum_y);
                        failures++;
                    end
                    if (sum_magnitude !== want.magnitude)
                    begin
                        $error("sum_magnitude: expected %0d, actual %0d",
                               want.magnitude, sum_magnitude);
                        failures++;
                    end
                    if (frame_done !== want.done)
                    begin
                        $error("frame_done: expected %0d, actual %0d", want.done, frame_done);
                        failures++;
                    end
                end
            end
            if (cfg_write_enable)
            begin
                if (cfg_index == fsat_pkg::REG_FRAME_WIDTH)
                begin
                    width_reg = cfg_data;
                    restart_frame();
                end
                else if (cfg_index == fsat_pkg::REG_FRAME_HEIGHT)
                begin
                    height_reg = cfg_data;
                    restart_frame();
                end
            end
            if (in_valid && !in_stall)
                sums_due.push_back(predict_area_sums(flow_x, flow_y));
            pending <= sums_due.size();
        end
    end

endmodule

>>> test/tb_flow_summed_area_table.sv
module tb_flow_summed_area_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int RANDOM_WORDS = 400;
    // The longest quiet stretch of a healthy run is the time the block spends
    // on one word plus a sender gap and a receiver stall run.
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [fsat_pkg::FLOW_W-1:0] FLOW_MIN = 16'sh8000;
    localparam logic signed [fsat_pkg::FLOW_W-1:0] FLOW_MAX = 16'sh7FFF;

    // Register indexes past the two real registers; writes to them must be
    // ignored and must not restart the frame.
    localparam logic [fsat_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [fsat_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    // Receiver behavior: take every word, stall about half the time, or
    // stall most of the time.
    typedef enum int {TAKE_ALL, TAKE_HALF, TAKE_RARELY} take_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                cfg_write_enable = 1'b0;
    logic [fsat_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [fsat_pkg::CFG_W-1:0]          cfg_data = '0;

    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [fsat_pkg::FLOW_W-1:0]  flow_x = '0;
    logic signed [fsat_pkg::FLOW_W-1:0]  flow_y = '0;

    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [fsat_pkg::SUM_W-1:0]   sum_x;
    logic signed [fsat_pkg::SUM_W-1:0]   sum_y;
    logic [fsat_pkg::SUM_W-1:0]          sum_magnitude;
    logic                                frame_done;

    int failures;
    int pending;

    // Sender burst bookkeeping, receiver pattern and watchdog.
    int burst_left = 0;
    take_mode_t take_mode = TAKE_ALL;
    int take_mode_left = 0;
    int quiet_cycles = 0;

    // Raw register contents as last written, used to size the frames.
    logic [fsat_pkg::CFG_W-1:0] width_now = fsat_pkg::DIM_RESET;
    logic [fsat_pkg::CFG_W-1:0] height_now = fsat_pkg::DIM_RESET;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    flow_summed_area_table #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .flow_x           (flow_x),
        .flow_y           (flow_y),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sum_x            (sum_x),
        .sum_y            (sum_y),
        .sum_magnitude    (sum_magnitude),
        .frame_done       (frame_done)
    );

    flow_sums_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) sums_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .flow_x           (flow_x),
        .flow_y           (flow_y),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sum_x            (sum_x),
        .sum_y            (sum_y),
        .sum_magnitude    (sum_magnitude),
        .frame_done       (frame_done),
        .failures         (failures),
        .pending          (pending)
    );

    // A flow component biased toward the extremes and toward small values,
    // with enough fully random values that every bit toggles.
    function automatic logic signed [fsat_pkg::FLOW_W-1:0] pick_flow();
        logic signed [fsat_pkg::FLOW_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = FLOW_MIN;
            1: v = FLOW_MAX;
            2: v = '0;
            3, 4, 5: v = fsat_pkg::FLOW_W'($urandom_range(0, 1023) - 512);
            default: v = fsat_pkg::FLOW_W'($urandom());
        endcase
        return v;
    endfunction

    // The frame dimension the block actually uses for a register value:
    // zero acts as one, anything above the maximum acts as the maximum.
    function automatic int live_dim(input logic [fsat_pkg::CFG_W-1:0] v, input int limit);
        if (v == 0)
            return 1;
        return (v > limit) ? limit : int'(v);
    endfunction

    // Offers one flow word and returns once it is taken, or after the gap when
    // that word ends a burst. The sender works in bursts; when a burst ends,
    // valid drops for a random, nonzero gap, so valid is never lowered and raised
    // in the same time step.
    task automatic send_word(input logic signed [fsat_pkg::FLOW_W-1:0] x,
                             input logic signed [fsat_pkg::FLOW_W-1:0] y);
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        in_valid <= 1'b1;
        flow_x <= x;
        flow_y <= y;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    endtask

    // Stops the sender and waits until every expected result word has been
    // taken. The first edge lets the checker count a word taken at the
    // current edge before its pending count is looked at.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One register write; the enable stays high for back-to-back writes and
    // is dropped by end_writes.
    task automatic write_reg(input logic [fsat_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fsat_pkg::CFG_W-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == fsat_pkg::REG_FRAME_WIDTH)
            width_now = value;
        else if (idx == fsat_pkg::REG_FRAME_HEIGHT)
            height_now = value;
    endtask

    task automatic end_writes();
        cfg_write_enable <= 1'b0;
    endtask

    // Writes both dimensions in a random order.
    task automatic set_shape(input logic [fsat_pkg::CFG_W-1:0] w,
                             input logic [fsat_pkg::CFG_W-1:0] h);
        wait_idle();
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(fsat_pkg::REG_FRAME_WIDTH, w);
            write_reg(fsat_pkg::REG_FRAME_HEIGHT, h);
        end
        else
        begin
            write_reg(fsat_pkg::REG_FRAME_HEIGHT, h);
            write_reg(fsat_pkg::REG_FRAME_WIDTH, w);
        end
        end_writes();
    endtask

    // The receiver keeps a pattern of its own, switching between taking
    // every word, stalling at random and stalling most of the time.
    always @(posedge clk)
    begin
        if (take_mode_left == 0)
        begin
            take_mode = take_mode_t'($urandom_range(0, 2));
            take_mode_left = $urandom_range(20, 400);
        end
        else
            take_mode_left--;
        case (take_mode)
            TAKE_ALL: out_stall <= 1'b0;
            TAKE_HALF: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Watchdog: a run in which no word moves on either channel for too long
    // has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int random_words;
        int pick;
        int area;
        int words;
        logic [fsat_pkg::CFG_W-1:0] w;
        logic [fsat_pkg::CFG_W-1:0] h;

        random_words = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset dimensions are the full 1024 x 1024 frame. Only part of the
        // bottom row is sent, with the component extremes; the largest
        // magnitude comes from both components at their most negative.
        send_word(FLOW_MAX, FLOW_MAX);
        send_word(FLOW_MIN, FLOW_MIN);
        send_word('0, '0);
        send_word(FLOW_MIN, FLOW_MAX);
        send_word(FLOW_MAX, FLOW_MIN);
        send_word(16'sd1, -16'sd1);

        // Zero dimensions act as a single pixel, so every word ends a frame.
        set_shape('0, '0);
        repeat (3) send_word(pick_flow(), pick_flow());

        // All-ones dimensions are clamped to the maximum frame.
        set_shape(11'h7FF, 11'h7FF);
        repeat (2) send_word(pick_flow(), pick_flow());

        // A 3 x 2 frame with writes to the unused indexes in the middle of
        // it; the frame must carry on, then wrap into the next one.
        set_shape(11'd3, 11'd2);
        repeat (4) send_word(pick_flow(), pick_flow());
        wait_idle();
        write_reg(REG_SPARE_2, '0);
        write_reg(REG_SPARE_3, 11'h7FF);
        end_writes();
        repeat (4) send_word(pick_flow(), pick_flow());

        // A one-pixel-wide column: every word above the bottom row reads the line
        // buffer entry just written by the word before.
        set_shape(11'd1, 11'd3);
        repeat (4) send_word(FLOW_MIN, pick_flow());

        // Random phases. Most use small frames sent whole, often several
        // frames in a row and sometimes a partial one at the end; a few use
        // clamped or very large dimensions with a short run of words.
        while (random_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 15);
            case (pick)
                0:
                begin
                    w = '0;
                    h = fsat_pkg::CFG_W'($urandom_range(1, 6));
                end
                1:
                begin
                    w = fsat_pkg::CFG_W'($urandom_range(1, 6));
                    h = '0;
                end
                2:
                begin
                    w = fsat_pkg::CFG_W'($urandom_range(1000, 2047));
                    h = fsat_pkg::CFG_W'($urandom_range(1, 3));
                end
                3:
                begin
                    w = fsat_pkg::CFG_W'($urandom_range(1, 3));
                    h = fsat_pkg::CFG_W'($urandom_range(1000, 2047));
                end
                default:
                begin
                    w = fsat_pkg::CFG_W'($urandom_range(1, 8));
                    h = fsat_pkg::CFG_W'($urandom_range(1, 8));
                end
            endcase

            // Sometimes only one register changes; a single write still
            // restarts the frame. Now and then an unused index is written.
            pick = $urandom_range(0, 5);
            wait_idle();
            if (pick == 0)
                write_reg(fsat_pkg::REG_FRAME_WIDTH, w);
            else if (pick == 1)
                write_reg(fsat_pkg::REG_FRAME_HEIGHT, h);
            else if ($urandom_range(0, 1) == 0)
            begin
                write_reg(fsat_pkg::REG_FRAME_WIDTH, w);
                write_reg(fsat_pkg::REG_FRAME_HEIGHT, h);
            end
            else
            begin
                write_reg(fsat_pkg::REG_FRAME_HEIGHT, h);
                write_reg(fsat_pkg::REG_FRAME_WIDTH, w);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                          fsat_pkg::CFG_W'($urandom()));
            end_writes();

            area = live_dim(width_now, MAX_WIDTH) * live_dim(height_now, MAX_HEIGHT);
            if (area > 64)
                words = $urandom_range(1, 40);
            else
            begin
                words = area * $urandom_range(1, 3);
                if ($urandom_range(0, 2) == 0)
                    words += $urandom_range(1, area);
            end
            repeat (words)
            begin
                send_word(pick_flow(), pick_flow());
                random_words++;
            end
        end

        // Drain: every expected result must arrive, and nothing may follow.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
